FILE: design/demand_page_translator_defines.svh
`ifndef DEMAND_PAGE_TRANSLATOR_DEFINES_SVH
`define DEMAND_PAGE_TRANSLATOR_DEFINES_SVH

// Both macros expect clk and arst_n in scope.
`define DPT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define DPT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/dpt_pkg.sv
package dpt_pkg;

	localparam int PAGE_BITS    = 10;
	localparam int NUM_PAGES    = 256;
	localparam int BUFFER_PAGES = 64;
	localparam int COARSE_BITS  = 12;

	localparam int ENTRY_W  = 18;
	localparam int ADDR_W   = 16;
	localparam int FIN_W    = 9;
	localparam int MISS_W   = 7;
	localparam int LIMIT_W  = 7;
	localparam int PAGE_W   = $clog2(NUM_PAGES);
	localparam int TGT_W    = $clog2(BUFFER_PAGES);
	localparam int FREE_W   = TGT_W + 1;
	localparam int MAP_BLOCKS = ((NUM_PAGES << PAGE_BITS) + (1 << COARSE_BITS) - 1) >> COARSE_BITS;
	localparam int BLK_W    = $clog2(MAP_BLOCKS);
	localparam int KIND_W   = 2;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(BUFFER_PAGES);

	localparam logic REQ_TRANSLATE = 1'b0;
	localparam logic REQ_END_ROUND = 1'b1;

	// Register word select is paddr[2].
	localparam logic REG_BUFFER_PAGES_LIMIT = 1'b0;

	typedef enum logic [KIND_W-1:0] {
		KIND_UNMAPPED = 2'd0,
		KIND_MAPPED   = 2'd1,
		KIND_FINISHED = 2'd2
	} kind_t;

	typedef struct packed {
		logic capture;
		logic translate;
		logic round_quick;
		logic sweep_start;
		logic sweep_step;
		logic round_finish;
	} dpt_cmd_t;

	typedef struct packed {
		logic req_end;
		logic flag;
		logic sweep_done;
		logic out_free;
	} dpt_stat_t;

endpackage

FILE: design/dpt_req_if.sv
interface dpt_req_if import dpt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               req_type;
	logic [ENTRY_W-1:0] entry_index;
	logic [ENTRY_W-1:0] source_index;

	modport source (output valid, req_type, entry_index, source_index, input ready);
	modport sink (input valid, req_type, entry_index, source_index, output ready);
endinterface

FILE: design/dpt_rsp_if.sv
interface dpt_rsp_if import dpt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] buffer_address;
	logic              stored;
	logic [FIN_W-1:0]  finished_count;
	logic [MISS_W-1:0] missed_blocks;
	logic              had_unstored;

	modport source (output valid, buffer_address, stored, finished_count, missed_blocks,
		had_unstored, input ready);
	modport sink (input valid, buffer_address, stored, finished_count, missed_blocks,
		had_unstored, output ready);
endinterface

FILE: design/dpt_ram.sv
module dpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: design/dpt_ctrl.sv
module dpt_ctrl import dpt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  dpt_stat_t stat,
	output dpt_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_EXEC   = 4'b0010,
		S_SWEEP  = 4'b0100,
		S_REPORT = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.out_free) begin
					if (!stat.req_end) begin
						cmd.translate = 1'b1;
						state_d       = S_IDLE;
					end else if (!stat.flag) begin
						cmd.round_quick = 1'b1;
						state_d         = S_IDLE;
					end else begin
						cmd.sweep_start = 1'b1;
						state_d         = S_SWEEP;
					end
				end
			end
			S_SWEEP: begin
				cmd.sweep_step = 1'b1;
				if (stat.sweep_done) begin
					state_d = S_REPORT;
				end
			end
			S_REPORT: begin
				if (stat.out_free) begin
					cmd.round_finish = 1'b1;
					state_d          = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: design/dpt_datapath.sv
module dpt_datapath import dpt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_req_type,
	input  logic [ENTRY_W-1:0] in_entry_index,
	input  logic [ENTRY_W-1:0] in_source_index,
	input  logic               cfg_we,
	input  logic [LIMIT_W-1:0] cfg_wdata,
	output logic [LIMIT_W-1:0] limit,
	input  dpt_cmd_t           cmd,
	output dpt_stat_t          stat,
	dpt_rsp_if.source          rsp
);

	logic [LIMIT_W-1:0]   limit_q;
	logic                 req_type_q;
	logic [PAGE_W-1:0]    page_q;
	logic [PAGE_BITS-1:0] offset_q;
	logic [BLK_W-1:0]     blk_q;
	logic [NUM_PAGES-1:0] valid_q;
	logic [MAP_BLOCKS-1:0] missed_q;
	logic                 flag_q;
	logic [FREE_W-1:0]    free_q;
	logic [PAGE_W-1:0]    cnt_q;
	logic [FIN_W-1:0]     fin_q;
	logic [MISS_W-1:0]    miss_cnt_q;
	logic                 out_valid_q;
	logic [ADDR_W-1:0]    addr_q;
	logic                 stored_q;
	logic [FIN_W-1:0]     fin_out_q;
	logic [MISS_W-1:0]    miss_out_q;
	logic                 had_q;

	logic [LIMIT_W-1:0] eff_limit;
	logic [KIND_W-1:0]  kind_rd;
	logic [TGT_W-1:0]   tgt_rd;
	kind_t              kind_eff;
	logic               shortage;
	logic               alloc;
	logic               hit;
	logic               sweep_mark;
	logic               kind_we;
	logic [PAGE_W-1:0]  kind_waddr;
	logic [KIND_W-1:0]  kind_wdata;
	logic [PAGE_W-1:0]  in_page;

	assign in_page   = in_entry_index[ENTRY_W-1:PAGE_BITS];
	assign eff_limit = (limit_q > LIMIT_W'(BUFFER_PAGES)) ? LIMIT_W'(BUFFER_PAGES) : limit_q;
	assign kind_eff  = valid_q[page_q] ? kind_t'(kind_rd) : KIND_UNMAPPED;

	always_comb begin
		hit      = 1'b0;
		shortage = 1'b0;
		alloc    = 1'b0;
		case (kind_eff)
			KIND_MAPPED: begin
				hit = 1'b1;
			end
			KIND_UNMAPPED: begin
				if (free_q >= FREE_W'(eff_limit)) begin
					shortage = 1'b1;
				end else begin
					alloc = 1'b1;
				end
			end
			default: begin
				hit = 1'b0;
			end
		endcase
	end

	assign sweep_mark = cmd.sweep_step && valid_q[cnt_q];
	assign kind_we    = (cmd.translate && alloc) || sweep_mark;
	assign kind_waddr = cmd.sweep_step ? cnt_q : page_q;
	assign kind_wdata = cmd.sweep_step ? KIND_FINISHED : KIND_MAPPED;

	dpt_ram #(.WIDTH(KIND_W), .DEPTH(NUM_PAGES)) u_kind_ram (
		.clk   (clk),
		.we    (kind_we),
		.waddr (kind_waddr),
		.wdata (kind_wdata),
		.re    (cmd.capture),
		.raddr (in_page),
		.rdata (kind_rd)
	);

	dpt_ram #(.WIDTH(TGT_W), .DEPTH(NUM_PAGES)) u_target_ram (
		.clk   (clk),
		.we    (cmd.translate && alloc),
		.waddr (page_q),
		.wdata (free_q[TGT_W-1:0]),
		.re    (cmd.capture),
		.raddr (in_page),
		.rdata (tgt_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_type_q <= in_req_type;
			page_q     <= in_page;
			offset_q   <= in_entry_index[PAGE_BITS-1:0];
			blk_q      <= in_source_index[ENTRY_W-1:COARSE_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q    <= LIMIT_RESET;
			valid_q    <= '0;
			missed_q   <= '0;
			flag_q     <= 1'b0;
			free_q     <= '0;
			cnt_q      <= '0;
			fin_q      <= '0;
			miss_cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (cmd.translate && alloc) begin
				valid_q[page_q] <= 1'b1;
				free_q          <= free_q + FREE_W'(1);
			end
			if (cmd.translate && shortage) begin
				missed_q[blk_q] <= 1'b1;
				flag_q          <= 1'b1;
			end
			if (cmd.round_quick) begin
				valid_q <= '0;
				free_q  <= '0;
			end
			if (cmd.sweep_start) begin
				free_q     <= '0;
				cnt_q      <= '0;
				fin_q      <= '0;
				miss_cnt_q <= '0;
			end
			if (cmd.sweep_step) begin
				cnt_q <= cnt_q + PAGE_W'(1);
				if (valid_q[cnt_q]) begin
					fin_q <= fin_q + FIN_W'(1);
				end
				if (cnt_q < PAGE_W'(MAP_BLOCKS) && missed_q[cnt_q[BLK_W-1:0]]) begin
					miss_cnt_q <= miss_cnt_q + MISS_W'(1);
				end
			end
			if (cmd.round_finish) begin
				missed_q <= '0;
				flag_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.translate || cmd.round_quick || cmd.round_finish) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.translate) begin
			fin_out_q  <= '0;
			miss_out_q <= '0;
			had_q      <= flag_q || shortage;
			stored_q   <= hit || alloc;
			if (hit) begin
				addr_q <= {tgt_rd, offset_q};
			end else if (alloc) begin
				addr_q <= {free_q[TGT_W-1:0], offset_q};
			end else begin
				addr_q <= '0;
			end
		end else if (cmd.round_quick || cmd.round_finish) begin
			addr_q     <= '0;
			stored_q   <= 1'b0;
			fin_out_q  <= cmd.round_finish ? fin_q : '0;
			miss_out_q <= cmd.round_finish ? miss_cnt_q : '0;
			had_q      <= cmd.round_finish;
		end
	end

	assign stat.req_end    = (req_type_q == REQ_END_ROUND);
	assign stat.flag       = flag_q;
	assign stat.sweep_done = (cnt_q == PAGE_W'(NUM_PAGES - 1));
	assign stat.out_free   = !out_valid_q || rsp.ready;

	assign limit              = limit_q;
	assign rsp.valid          = out_valid_q;
	assign rsp.buffer_address = addr_q;
	assign rsp.stored         = stored_q;
	assign rsp.finished_count = fin_out_q;
	assign rsp.missed_blocks  = miss_out_q;
	assign rsp.had_unstored   = had_q;

endmodule

FILE: design/demand_page_translator.sv
// Demand-paged address translator. For a translate item, the cycle in which it is accepted
// presents its page number to the page-kind and page-target memories, and the execute state
// then reads their registered outputs, allocates a buffer page if needed and within the
// limit, and loads the result register. An end-of-round item with no dropped requests
// clears all the per-page valid bits together in the execute state. An end-of-round item after a
// dropped request walks the page-kind memory one entry per cycle, marking mapped pages
// finished while counting them and the missed blocks. Any of these waits further while the
// previous result has not been taken. The next item is accepted once the current one has
// reached the result register.
`include "demand_page_translator_defines.svh"

module demand_page_translator import dpt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	dpt_req_if.sink            req,
	dpt_rsp_if.source          rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	dpt_cmd_t           cmd;
	dpt_stat_t          stat;
	logic               cfg_we;
	logic [LIMIT_W-1:0] limit;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_BUFFER_PAGES_LIMIT);
	assign prdata = (paddr[2] == REG_BUFFER_PAGES_LIMIT) ? PDATA_W'(limit) : '0;

	dpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dpt_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_req_type     (req.req_type),
		.in_entry_index  (req.entry_index),
		.in_source_index (req.source_index),
		.cfg_we          (cfg_we),
		.cfg_wdata       (pwdata[LIMIT_W-1:0]),
		.limit           (limit),
		.cmd             (cmd),
		.stat            (stat),
		.rsp             (rsp)
	);

	`DPT_ASSERT_NEXT(a_one_item_at_a_time, req.valid && req.ready, !req.ready, "item accepted while busy")
	`DPT_ASSERT_SAME(a_stored_no_counts, rsp.valid && rsp.stored, (rsp.finished_count == '0) && (rsp.missed_blocks == '0), "stored result carries round counts")
	`DPT_ASSERT_SAME(a_finished_needs_flag, rsp.valid && (rsp.finished_count != '0), rsp.had_unstored, "finished pages without a dropped request")
	`DPT_ASSERT_SAME(a_sweep_owns_flow, cmd.sweep_step, !req.ready && !cmd.translate, "translate during the page walk")

endmodule
